// ===== design/assert_macros.svh =====
// Assertion macros shared by the evaluator RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Expression never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== design/bpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the bivariate evaluator.
// No dependencies; used by the evaluator RTL and the bench.
package bpe_pkg;

    localparam int MAX_DEGREE    = 4;
    localparam int XY_FRAC_BITS  = 16;
    localparam int NUM_COEFS     = 15;
    localparam int NUM_STEPS     = MAX_DEGREE;
    localparam int SCALE_STAGES  = 2 * NUM_STEPS;
    localparam int ADDS_PER_STG  = 3;
    localparam int SUM_STAGES    = (NUM_COEFS + ADDS_PER_STG - 1) / ADDS_PER_STG;

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic REG_DEGREE = 1'b0;

    localparam logic [2:0] POW_X [NUM_COEFS] = '{3'd0, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0, 3'd3,
        3'd2, 3'd1, 3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [2:0] POW_Y [NUM_COEFS] = '{3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd0,
        3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

    typedef enum logic [1:0] {
        OPER_NONE = 2'd0,
        OPER_X    = 2'd1,
        OPER_Y    = 2'd2
    } t_oper;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  coef_index;
        logic [63:0] coef_value;
        logic [31:0] x_coord;
        logic [31:0] y_coord;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] poly_value;
        logic        overflow;
    } t_out_beat;

    // Which operand step s of term k multiplies by: all x powers first, then y.
    function automatic t_oper step_oper(input int k, input int s);
        t_oper res;
        res = OPER_NONE;
        if (s < int'(POW_X[k])) begin
            res = OPER_X;
        end else if (s < int'(POW_X[k]) + int'(POW_Y[k])) begin
            res = OPER_Y;
        end
        return res;
    endfunction

    // Terms summed for a degree already clamped to 1..MAX_DEGREE.
    function automatic logic [3:0] num_terms(input logic [2:0] d);
        logic [3:0] n;
        unique case (d)
            3'd1:    n = 4'd3;
            3'd2:    n = 4'd6;
            3'd3:    n = 4'd10;
            default: n = 4'd15;
        endcase
        return n;
    endfunction

    // Saturating signed add; top bit of the result flags saturation.
    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        logic [64:0] res;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            res = {1'b1, (a[63] ? NEG_MIN : POS_MAX)};
        end else begin
            res = {1'b0, s};
        end
        return res;
    endfunction

endpackage

// ===== design/bpe_scale.sv =====
`timescale 1ns / 1ps
// One rounded, saturated Q24.40 by Q16.16 multiply step, two register stages.
// Depends on bpe_pkg for the fraction width and saturation limits.
module bpe_scale (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_act,
    input  logic [63:0] i_value,
    input  logic        i_ov,
    input  logic [31:0] i_oper,
    output logic [63:0] o_value,
    output logic        o_ov
);

    localparam int F = bpe_pkg::XY_FRAC_BITS;
    localparam logic [96:0] RND = (F > 0) ? (97'd1 << ((F > 0) ? F - 1 : 0)) : 97'd0;

    logic [63:0] w_cm;
    logic [31:0] w_vm;
    logic        r_neg;
    logic        r_act;
    logic        r_ov_a;
    logic [63:0] r_pass;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic [63:0] r_value;
    logic        r_ov_b;

    logic [96:0] w_prod;
    logic [63:0] w_mag;
    logic        w_big;
    logic [63:0] n_value;
    logic        n_sat;

    // Stage A: magnitudes and the two 32x32 partial products.
    assign w_cm = i_value[63] ? (~i_value + 64'd1) : i_value;
    assign w_vm = i_oper[31] ? (~i_oper + 32'd1) : i_oper;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= i_value[63] ^ i_oper[31];
            r_act  <= i_act;
            r_ov_a <= i_ov;
            r_pass <= i_value;
            r_plo  <= w_cm[31:0] * w_vm;
            r_phi  <= w_cm[63:32] * w_vm;
        end
    end

    // Stage B: combine, round half away from zero, rescale, saturate.
    assign w_prod = {1'b0, r_phi, 32'd0} + {33'd0, r_plo} + RND;
    assign w_mag  = w_prod[63 + F:F];
    assign w_big  = (w_prod[96:64 + F] != '0);

    always_comb begin
        n_value = r_pass;
        n_sat   = 1'b0;
        if (r_act) begin
            if (w_big) begin
                n_sat   = 1'b1;
                n_value = r_neg ? bpe_pkg::NEG_MIN : bpe_pkg::POS_MAX;
            end else if (!r_neg) begin
                if (w_mag[63]) begin
                    n_sat   = 1'b1;
                    n_value = bpe_pkg::POS_MAX;
                end else begin
                    n_value = w_mag;
                end
            end else if (w_mag > bpe_pkg::NEG_MIN) begin
                n_sat   = 1'b1;
                n_value = bpe_pkg::NEG_MIN;
            end else begin
                n_value = ~w_mag + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_ov_b  <= r_ov_a | n_sat;
        end
    end

    assign o_value = r_value;
    assign o_ov    = r_ov_b;

endmodule

// ===== design/bpe_sum.sv =====
`timescale 1ns / 1ps
// Pipelined saturating sum of the terms in index order, a few adds a stage.
// Depends on bpe_pkg for sizes and the saturating add.
module bpe_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_terms [bpe_pkg::NUM_COEFS],
    input  logic        i_ov,
    output logic        o_vld,
    output logic [63:0] o_acc,
    output logic        o_ov
);

    localparam int NS = bpe_pkg::SUM_STAGES;
    localparam int NC = bpe_pkg::NUM_COEFS;
    localparam int AP = bpe_pkg::ADDS_PER_STG;

    logic        r_vld   [NS];
    logic [63:0] r_acc   [NS];
    logic        r_ov    [NS];
    logic [63:0] r_terms [NS][NC];

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_stage
            logic        w_vld;
            logic [63:0] w_acc;
            logic        w_ov;
            logic [63:0] w_terms [NC];
            logic [63:0] n_acc;
            logic        n_ov;

            if (j == 0) begin : g_first
                assign w_vld   = i_vld;
                assign w_acc   = '0;
                assign w_ov    = i_ov;
                assign w_terms = i_terms;
            end else begin : g_next
                assign w_vld   = r_vld[j - 1];
                assign w_acc   = r_acc[j - 1];
                assign w_ov    = r_ov[j - 1];
                assign w_terms = r_terms[j - 1];
            end

            always_comb begin
                logic [64:0] sa;
                n_acc = w_acc;
                n_ov  = w_ov;
                for (int a = 0; a < AP; a++) begin
                    if (j * AP + a < NC) begin
                        sa    = bpe_pkg::sat_add(n_acc, w_terms[j * AP + a]);
                        n_acc = sa[63:0];
                        n_ov  = n_ov | sa[64];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_vld[j] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_acc[j]   <= n_acc;
                    r_ov[j]    <= n_ov;
                    r_terms[j] <= w_terms;
                end
            end
        end
    endgenerate

    assign o_vld = r_vld[NS - 1];
    assign o_acc = r_acc[NS - 1];
    assign o_ov  = r_ov[NS - 1];

endmodule

// ===== design/bivariate_poly_eval_unit.sv =====
`timescale 1ns / 1ps
// Bivariate polynomial evaluator top level: registers, coefficient store, lanes.
// Depends on bpe_pkg, bpe_scale, bpe_sum and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per
//   cycle while o_in_ready is high. A load beat (opcode 0) writes one of 15
//   coefficients and gives no result; an evaluate beat (opcode 1) gives one
//   output beat holding the polynomial value at (x, y) and an overflow flag.
//   Output channel (o_out_valid / i_out_ready / o_out_data) delivers results
//   in the order the evaluate beats were taken.
//   Acceptance to o_out_valid passes one input stage, two stages for each
//   of the four multiply steps (partial products, then round and saturate),
//   and five summing stages of three adds each. Throughput is one beat per
//   cycle while results are taken; the 64x32 multiply split over two stages
//   sets the stage count. The user must write the degree register over the
//   APB port while the block idles; the block itself does not enforce it.
//   Reset clears the valid bits and sets degree to 1; coefficients keep
//   whatever they held until loaded.
//   When the receiver stalls, the whole pipeline holds and o_in_ready drops
//   only while the output register is full and not taken.
module bivariate_poly_eval_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bpe_pkg::t_in_beat    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bpe_pkg::t_out_beat   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

`include "assert_macros.svh"

    localparam int NC = bpe_pkg::NUM_COEFS;
    localparam int NS = bpe_pkg::NUM_STEPS;
    localparam int SS = bpe_pkg::SCALE_STAGES;

    logic [2:0]  r_degree;
    logic [2:0]  w_deg;
    logic [3:0]  w_terms;
    logic [63:0] r_coefs [NC];
    logic        w_en;
    logic        w_acc;
    logic [SS:0] r_vld;
    logic [31:0] r_x [SS - 1];
    logic [31:0] r_y [SS - 1];
    logic [63:0] r_c0 [NC];
    logic [63:0] w_val [NC][NS + 1];
    logic        w_ov  [NC][NS + 1];
    logic [63:0] w_sum_terms [NC];
    logic        w_sum_ov;
    logic        w_out_ov;
    logic [63:0] w_out_acc;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bpe_pkg::REG_DEGREE) ? {29'd0, r_degree} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd1;
        end else if (psel && penable && pwrite && paddr[2] == bpe_pkg::REG_DEGREE) begin
            r_degree <= pwdata[2:0];
        end
    end

    always_comb begin
        w_deg = r_degree;
        if (r_degree == 3'd0) begin
            w_deg = 3'd1;
        end else if (r_degree > 3'(bpe_pkg::MAX_DEGREE)) begin
            w_deg = 3'(bpe_pkg::MAX_DEGREE);
        end
    end
    assign w_terms = bpe_pkg::num_terms(w_deg);

    // Whole pipeline advances whenever the output register can move.
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;

    // Coefficient store; the last index code writes nothing.
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in_data.opcode == bpe_pkg::OP_LOAD && i_in_data.coef_index != 4'd15) begin
            r_coefs[i_in_data.coef_index] <= i_in_data.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[SS - 1:0], i_in_valid && i_in_data.opcode == bpe_pkg::OP_EVAL};
        end
    end

    // Input stage: capture the point and the terms in use, zero the rest.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= i_in_data.x_coord;
            r_y[0] <= i_in_data.y_coord;
            for (int k = 0; k < NC; k++) begin
                r_c0[k] <= (4'(k) < w_terms) ? r_coefs[k] : 64'd0;
            end
            for (int i = 1; i < SS - 1; i++) begin
                r_x[i] <= r_x[i - 1];
                r_y[i] <= r_y[i - 1];
            end
        end
    end

    genvar k, s;
    generate
        for (k = 0; k < NC; k++) begin : g_lane
            assign w_val[k][0] = r_c0[k];
            assign w_ov[k][0]  = 1'b0;
            for (s = 0; s < NS; s++) begin : g_step
                localparam bpe_pkg::t_oper OPER = bpe_pkg::step_oper(k, s);
                bpe_scale u_scale (
                    .i_clk   (i_clk),
                    .i_en    (w_en),
                    .i_act   (OPER != bpe_pkg::OPER_NONE),
                    .i_value (w_val[k][s]),
                    .i_ov    (w_ov[k][s]),
                    .i_oper  ((OPER == bpe_pkg::OPER_Y) ? r_y[2 * s] : r_x[2 * s]),
                    .o_value (w_val[k][s + 1]),
                    .o_ov    (w_ov[k][s + 1])
                );
            end
        end
    endgenerate

    always_comb begin
        w_sum_ov = 1'b0;
        for (int i = 0; i < NC; i++) begin
            w_sum_terms[i] = w_val[i][NS];
            w_sum_ov       = w_sum_ov | w_ov[i][NS];
        end
    end

    bpe_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld[SS]),
        .i_terms (w_sum_terms),
        .i_ov    (w_sum_ov),
        .o_vld   (o_out_valid),
        .o_acc   (w_out_acc),
        .o_ov    (w_out_ov)
    );

    assign o_out_data.poly_value = w_out_acc;
    assign o_out_data.overflow   = w_out_ov;

    `ASSERT_AT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)
    `ASSERT_AT(a_out_rise_on_advance, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(w_en))
    `ASSERT_AT(a_hold_on_stall, i_clk, i_rst_n, !w_en |=> $stable(r_vld))

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Bench for bivariate_poly_eval_unit: directed table, then randomised phases
// across all degrees; results checked against table values or an in-bench
// fixed-point evaluator. Depends on bpe_pkg and the evaluator RTL.
module tb;

    typedef struct {
        bpe_pkg::t_in_beat beat;
        logic              typed;
        logic [63:0]       val;
        logic              ovf;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    bpe_pkg::t_in_beat  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    bpe_pkg::t_out_beat o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [63:0]        coef_store [bpe_pkg::NUM_COEFS];
    logic [2:0]         cur_degree;
    bpe_pkg::t_out_beat pending_values [$];
    int                 errors = 0;
    logic               calm = 1'b0;
    logic               row_typed = 1'b0;
    logic [63:0]        row_val = '0;
    logic               row_ovf = 1'b0;
    t_row               rows [$];

    bivariate_poly_eval_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Q24.40 times Q16.16, magnitude rounded half away from zero, saturated.
    function automatic logic [63:0] mul_q16(input logic [63:0] c, input logic [31:0] v,
                                            inout logic ovf);
        logic        neg;
        logic [63:0] cm;
        logic [31:0] vm;
        logic [95:0] prod;
        logic [63:0] mag;
        neg  = c[63] ^ v[31];
        cm   = c[63] ? -c : c;
        vm   = v[31] ? -v : v;
        prod = {32'd0, cm} * {64'd0, vm};
        prod = prod + 96'd32768;
        if (prod[95:80] != 0) begin
            ovf = 1'b1;
            return neg ? bpe_pkg::NEG_MIN : bpe_pkg::POS_MAX;
        end
        mag = prod[79:16];
        if (!neg && mag > bpe_pkg::POS_MAX) begin
            ovf = 1'b1;
            return bpe_pkg::POS_MAX;
        end
        if (neg && mag > bpe_pkg::NEG_MIN) begin
            ovf = 1'b1;
            return bpe_pkg::NEG_MIN;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic bpe_pkg::t_out_beat poly_at(input logic [31:0] x,
                                                   input logic [31:0] y);
        int                 d;
        int                 n;
        logic [63:0]        t;
        logic [63:0]        acc;
        logic [63:0]        s;
        logic               ovf;
        bpe_pkg::t_out_beat r;
        d   = (cur_degree < 1) ? 1 : (cur_degree > bpe_pkg::MAX_DEGREE ?
                                      bpe_pkg::MAX_DEGREE : cur_degree);
        n   = (d + 1) * (d + 2) / 2;
        acc = '0;
        ovf = 1'b0;
        for (int k = 0; k < n; k++) begin
            t = coef_store[k];
            for (int i = 0; i < bpe_pkg::POW_X[k]; i++) t = mul_q16(t, x, ovf);
            for (int j = 0; j < bpe_pkg::POW_Y[k]; j++) t = mul_q16(t, y, ovf);
            s = acc + t;
            if (acc[63] == t[63] && s[63] != acc[63]) begin
                ovf = 1'b1;
                s   = acc[63] ? bpe_pkg::NEG_MIN : bpe_pkg::POS_MAX;
            end
            acc = s;
        end
        r.poly_value = acc;
        r.overflow   = ovf;
        return r;
    endfunction

    // Track accepted beats: update the store on loads, queue a result on evaluates.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_in_data.opcode == bpe_pkg::OP_LOAD) begin
                if (i_in_data.coef_index < bpe_pkg::NUM_COEFS)
                    coef_store[i_in_data.coef_index] = i_in_data.coef_value;
            end else if (row_typed) begin
                pending_values.push_back('{poly_value: row_val, overflow: row_ovf});
            end else begin
                pending_values.push_back(poly_at(i_in_data.x_coord, i_in_data.y_coord));
            end
        end
    end

    always @(posedge i_clk) begin
        bpe_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected result %h/%b", $time,
                         o_out_data.poly_value, o_out_data.overflow);
                errors++;
            end else begin
                want = pending_values.pop_front();
                if (want.poly_value !== o_out_data.poly_value) begin
                    $display("%0t: poly_value expected %h actual %h", $time,
                             want.poly_value, o_out_data.poly_value);
                    errors++;
                end
                if (want.overflow !== o_out_data.overflow) begin
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, o_out_data.overflow);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
    end

    task automatic send(input bpe_pkg::t_in_beat b, input logic typed,
                        input logic [63:0] v, input logic o);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 35) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = b;
        row_typed  = typed;
        row_val    = v;
        row_ovf    = o;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_degree(input logic [2:0] d);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = 3'(4 * bpe_pkg::REG_DEGREE); pwdata = 32'(d);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        cur_degree = d;
    endtask

    function automatic bpe_pkg::t_in_beat load_beat(input int idx, input logic [63:0] v);
        bpe_pkg::t_in_beat b;
        b            = '0;
        b.opcode     = bpe_pkg::OP_LOAD;
        b.coef_index = 4'(idx);
        b.coef_value = v;
        b.x_coord    = $urandom;
        b.y_coord    = $urandom;
        return b;
    endfunction

    function automatic bpe_pkg::t_in_beat eval_beat(input logic [31:0] x,
                                                    input logic [31:0] y);
        bpe_pkg::t_in_beat b;
        b            = '0;
        b.opcode     = bpe_pkg::OP_EVAL;
        b.coef_index = 4'($urandom);
        b.coef_value = {$urandom, $urandom};
        b.x_coord    = x;
        b.y_coord    = y;
        return b;
    endfunction

    function automatic logic [63:0] pick_coef;
        logic [63:0] v;
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: v = ($urandom_range(2, 0) == 0) ? bpe_pkg::POS_MAX :
                   ($urandom_range(1) ? bpe_pkg::NEG_MIN : 64'd0);
            2: v = {20'd0, 4'($urandom_range(8)), 8'($urandom), $urandom};
            default: v = {32'd0, $urandom};
        endcase
        if (v != bpe_pkg::POS_MAX && v != bpe_pkg::NEG_MIN && $urandom_range(1)) v = -v;
        return v;
    endfunction

    function automatic logic [31:0] pick_coord;
        logic [31:0] v;
        if ($urandom_range(3) == 0) return $urandom;
        v = {14'd0, 2'($urandom_range(3)), 16'($urandom)};
        return $urandom_range(1) ? -v : v;
    endfunction

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int phase_deg [6] = '{2, 3, 4, 1, 4, 2};
        bpe_pkg::t_in_beat b;
        cur_degree = 3'd1;
        for (int k = 0; k < bpe_pkg::NUM_COEFS; k++) coef_store[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: fill every slot, then extremes and the ignored slot.
        for (int k = 0; k < bpe_pkg::NUM_COEFS; k++)
            rows.push_back('{load_beat(k, 64'(k + 1) << 40), 1'b0, '0, 1'b0});
        rows.push_back('{eval_beat(32'd0, 32'd0), 1'b1, 64'd1 << 40, 1'b0});
        rows.push_back('{eval_beat(32'h0001_0000, 32'd0), 1'b1, 64'd3 << 40, 1'b0});
        rows.push_back('{load_beat(1, bpe_pkg::POS_MAX), 1'b0, '0, 1'b0});
        rows.push_back('{eval_beat(32'h7FFF_FFFF, 32'd0), 1'b1, bpe_pkg::POS_MAX, 1'b1});
        rows.push_back('{load_beat(15, 64'hDEAD_BEEF_0BAD_F00D), 1'b0, '0, 1'b0});
        rows.push_back('{eval_beat(32'h8000_0000, 32'h8000_0000), 1'b0, '0, 1'b0});
        rows.push_back('{load_beat(0, bpe_pkg::NEG_MIN), 1'b0, '0, 1'b0});
        rows.push_back('{eval_beat(32'hFFFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0, 1'b0});
        rows.push_back('{eval_beat(32'hFFFF_0000, 32'h0000_8000), 1'b0, '0, 1'b0});
        foreach (rows[r]) send(rows[r].beat, rows[r].typed, rows[r].val, rows[r].ovf);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_degree(3'(phase_deg[p]));
            calm = (p == 2);
            for (int n = 0; n < 230; n++) begin
                if (n == 115 && p == 1) drain();
                if ($urandom_range(99) < 30)
                    b = load_beat($urandom_range(15), pick_coef());
                else
                    b = eval_beat(pick_coord(), pick_coord());
                send(b, 1'b0, '0, 1'b0);
            end
            calm = 1'b0;
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_values.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
